### rtl/orbit_camera_position_assert.svh
// Assertion macros for the orbit camera position block.
`ifndef ORBIT_CAMERA_POSITION_ASSERT_SVH
`define ORBIT_CAMERA_POSITION_ASSERT_SVH

// Clocked property, disabled while reset is low.
`define OCP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ocp: property failed");

// A stalled word keeps its payload.
`define OCP_ASSERT_STABLE(name, clk, rst_n, vld, rdy, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> $stable(sig)) else $error("ocp: stalled payload moved");

`endif

### rtl/ocp_pkg.sv
// ---------------------------------------------------------------------------
// ocp_pkg
// Shared widths, register indexes and controller command type.
// ---------------------------------------------------------------------------
package ocp_pkg;

  localparam int STEPS_PER_PI_DEF = 400;
  localparam int TRIG_BITS_DEF    = 16;

  localparam int MOVE_W = 11;
  localparam int POS_W  = 17;
  localparam int HDG_W  = 11;
  localparam int ELV_W  = 9;
  localparam int DIST_W = 16;
  localparam int LIM_W  = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIST_W;

  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ELEV_LIMIT = CFG_IDX_W'(1);

  localparam logic [DIST_W-1:0] DIST_RESET = 16'd1280;
  localparam logic [LIM_W-1:0]  LIM_RESET  = 8'd199;

  typedef enum logic [1:0] {
    SEL_SE = 2'd0,
    SEL_CE = 2'd1,
    SEL_SH = 2'd2,
    SEL_CH = 2'd3
  } ang_sel_e;

  typedef struct packed {
    logic     load_angles;
    logic     rd_en;
    ang_sel_e sel;
    logic     mul_y;
    logic     mul_t;
    logic     mul_z;
    logic     mul_use_t;
    logic     load_out;
  } ocp_cmd_t;

endpackage

### rtl/ocp_in_if.sv
// ---------------------------------------------------------------------------
// ocp_in_if
// Pointer move channel: valid/ready with dx, dy.
// ---------------------------------------------------------------------------
interface ocp_in_if;
  import ocp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [MOVE_W-1:0] dx;
  logic signed [MOVE_W-1:0] dy;

  modport source (output valid, output dx, output dy, input ready);
  modport sink   (input valid, input dx, input dy, output ready);
endinterface

### rtl/ocp_out_if.sv
// ---------------------------------------------------------------------------
// ocp_out_if
// Eye position channel: valid/ready with position and angles.
// ---------------------------------------------------------------------------
interface ocp_out_if;
  import ocp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [HDG_W-1:0] heading;
  logic signed [ELV_W-1:0] elevation;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output heading, output elevation, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input heading, input elevation, output ready);
endinterface

### rtl/ocp_ctrl.sv
// ---------------------------------------------------------------------------
// ocp_ctrl
// Sequencer: angle update, four table reads, four shared multiplies.
// ---------------------------------------------------------------------------
module ocp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output ocp_pkg::ocp_cmd_t cmd_o
);
  import ocp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RSE  = 6'b000010,
    S_RCE  = 6'b000100,
    S_RSH  = 6'b001000,
    S_RCH  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_SE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_angles = 1'b1;
          state_d           = S_RSE;
        end
      end
      S_RSE: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.sel   = SEL_SE;
        state_d     = S_RCE;
      end
      S_RCE: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.sel   = SEL_CE;
        cmd_o.mul_y = 1'b1;
        state_d     = S_RSH;
      end
      S_RSH: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.sel   = SEL_SH;
        cmd_o.mul_t = 1'b1;
        state_d     = S_RCH;
      end
      S_RCH: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.sel       = SEL_CH;
        cmd_o.mul_z     = 1'b1;
        cmd_o.mul_use_t = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        cmd_o.mul_use_t = 1'b1;
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/ocp_dpath.sv
// ---------------------------------------------------------------------------
// ocp_dpath
// Angle state, sine ROM, shared multiplier and output register.
// ---------------------------------------------------------------------------
module ocp_dpath #(
  parameter int STEPS_PER_PI = ocp_pkg::STEPS_PER_PI_DEF,
  parameter int TRIG_BITS    = ocp_pkg::TRIG_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ocp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ocp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [ocp_pkg::MOVE_W-1:0]   dx_i,
  input  logic signed [ocp_pkg::MOVE_W-1:0]   dy_i,
  input  ocp_pkg::ocp_cmd_t                   cmd_i,
  output logic signed [ocp_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [ocp_pkg::POS_W-1:0]    pos_y_o,
  output logic signed [ocp_pkg::POS_W-1:0]    pos_z_o,
  output logic signed [ocp_pkg::HDG_W-1:0]    heading_o,
  output logic signed [ocp_pkg::ELV_W-1:0]    elevation_o
);
  import ocp_pkg::*;

  localparam int FULL      = 2 * STEPS_PER_PI;
  localparam int QUARTER   = STEPS_PER_PI / 2;
  localparam int FRAC      = TRIG_BITS - 1;
  localparam int ROM_DEPTH = QUARTER + 1;
  localparam int IW        = $clog2(ROM_DEPTH);
  localparam int AW        = $clog2(2 * FULL + 1025) + 1;
  localparam int HD_W      = $clog2(FULL + 1) + 1;
  localparam int EL_W      = $clog2(QUARTER + 1) + 1;
  localparam int PW        = DIST_W + TRIG_BITS;

  localparam logic signed [AW-1:0] FULL_A    = AW'(FULL);
  localparam logic signed [AW-1:0] STEPS_A   = AW'(STEPS_PER_PI);
  localparam logic signed [AW-1:0] QUARTER_A = AW'(QUARTER);
  localparam logic [PW:0]          RND_HALF  = (PW + 1)'(1) << (FRAC - 1);

  typedef logic [TRIG_BITS-1:0] rom_t [ROM_DEPTH];

  // Quarter-wave sine in Q(FRAC), Taylor series in Q2.30, products truncated.
  function automatic logic [TRIG_BITS-1:0] sine_entry(int unsigned m);
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] v;
    logic [63:0] one;
    x    = (64'd3373259426 * 64'(m)) / 64'(STEPS_PER_PI);
    s    = x;
    term = x;
    one  = 64'd1 << FRAC;
    for (int n = 1; n <= 10; n++) begin
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) begin
        s = s - term;
      end else begin
        s = s + term;
      end
    end
    v = (s + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    if (v > one) begin
      v = one;
    end
    return TRIG_BITS'(v);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      r[k] = sine_entry(k);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic signed [POS_W-1:0] apply_sign(logic [DIST_W-1:0] mag,
                                                         logic neg);
    logic signed [POS_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // Configuration
  logic [DIST_W-1:0] dist_q;
  logic [LIM_W-1:0]  lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= DIST_RESET;
      lim_q  <= LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DISTANCE:   dist_q <= cfg_data_i;
        REG_ELEV_LIMIT: lim_q  <= cfg_data_i[LIM_W-1:0];
      endcase
    end
  end

  // Angle update
  logic signed [HD_W-1:0] hd_q;
  logic signed [EL_W-1:0] el_q;
  logic signed [AW-1:0]   dx_a, dy_a, dx_s, dy_s, h_sum, h_new, e_sum, e_new;
  logic signed [AW-1:0]   lim_raw, lim_a;

  always_comb begin
    dx_a = AW'(dx_i);
    dy_a = AW'(dy_i);
    dx_s = (dx_a > FULL_A) ? FULL_A : ((dx_a < -FULL_A) ? -FULL_A : dx_a);
    dy_s = (dy_a > FULL_A) ? FULL_A : ((dy_a < -FULL_A) ? -FULL_A : dy_a);

    h_sum = AW'(hd_q) + dx_s;
    priority if (h_sum > FULL_A) begin
      h_new = h_sum - FULL_A;
    end else if (h_sum < -FULL_A) begin
      h_new = h_sum + FULL_A;
    end else begin
      h_new = h_sum;
    end

    lim_raw = $signed(AW'(lim_q));
    lim_a   = (lim_raw > QUARTER_A) ? QUARTER_A : lim_raw;
    e_sum   = AW'(el_q) + dy_s;
    priority if (e_sum > lim_a) begin
      e_new = lim_a;
    end else if (e_sum < -lim_a) begin
      e_new = -lim_a;
    end else begin
      e_new = e_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_q <= '0;
      el_q <= '0;
    end else if (cmd_i.load_angles) begin
      hd_q <= HD_W'(h_new);
      el_q <= EL_W'(e_new);
    end
  end

  // Table address: reduce to a half turn, sign from the half, mirror the quarter
  logic signed [AW-1:0] ang, red, half;
  logic                 rd_neg;
  logic [IW-1:0]        rd_idx;

  always_comb begin
    unique case (cmd_i.sel)
      SEL_SE: ang = AW'(el_q);
      SEL_CE: ang = AW'(el_q) + QUARTER_A;
      SEL_SH: ang = AW'(hd_q);
      SEL_CH: ang = AW'(hd_q) + QUARTER_A;
      default: ang = '0;
    endcase
    priority if (ang < 0) begin
      red = ang + FULL_A;
    end else if (ang >= FULL_A) begin
      red = ang - FULL_A;
    end else begin
      red = ang;
    end
    rd_neg = (red > STEPS_A);
    half   = rd_neg ? red - STEPS_A : red;
    rd_idx = ((half + half) <= STEPS_A) ? IW'(half) : IW'(STEPS_A - half);
  end

  logic [TRIG_BITS-1:0] rom_q;
  logic se_neg_q, ce_neg_q, sh_neg_q, ch_neg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rom_q <= SINE_ROM[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      unique case (cmd_i.sel)
        SEL_SE: se_neg_q <= rd_neg;
        SEL_CE: ce_neg_q <= rd_neg;
        SEL_SH: sh_neg_q <= rd_neg;
        SEL_CH: ch_neg_q <= rd_neg;
        default: ;
      endcase
    end
  end

  // Shared multiplier, rounded half up to FRAC bits
  logic [DIST_W-1:0] op_a, mag, t_q, y_mag_q, z_mag_q;
  logic [PW-1:0]     prod;
  logic [PW:0]       rnd_sum;

  assign op_a    = cmd_i.mul_use_t ? t_q : dist_q;
  assign prod    = op_a * rom_q;
  assign rnd_sum = {1'b0, prod} + RND_HALF;
  assign mag     = rnd_sum[FRAC +: DIST_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_y) y_mag_q <= mag;
    if (cmd_i.mul_t) t_q     <= mag;
    if (cmd_i.mul_z) z_mag_q <= mag;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pos_x_o     <= apply_sign(mag, ce_neg_q ^ ch_neg_q);
      pos_y_o     <= apply_sign(y_mag_q, se_neg_q);
      pos_z_o     <= apply_sign(z_mag_q, ce_neg_q ^ sh_neg_q);
      heading_o   <= HDG_W'(hd_q);
      elevation_o <= ELV_W'(el_q);
    end
  end

endmodule

### rtl/orbit_camera_position.sv
// ---------------------------------------------------------------------------
// orbit_camera_position
// Orbit camera: pointer moves in, eye position on a sphere out.
// ---------------------------------------------------------------------------
// Usage:
//   in_i   : one word per pointer move (dx, dy in pi/STEPS_PER_PI counts,
//            saturated to a full turn).
//   out_o  : one word per move: eye x/y/z in signed Q9.8 plus the heading
//            and elevation after the move.
//   cfg_*  : write-only registers, distance (index 0, Q8.8 radius) and
//            elevation_limit (index 1); write only while the block is idle.
// Sequence:
//   A move is accepted in the idle step, then runs through RSE, RCE, RSH,
//   RCH and OUT before its result is registered; no new move is taken until
//   the block is back in idle. The single sine ROM port and the one shared
//   multiplier set this order: four lookups and four multiplies run in series.
// Reset:
//   heading and elevation go to zero, distance to 5.0, limit to 199.
// Stall:
//   a result waits in the output register; the next move is still taken
//   and runs until its final multiply, where it holds until out_o drains.
// ---------------------------------------------------------------------------
module orbit_camera_position #(
  parameter int STEPS_PER_PI = ocp_pkg::STEPS_PER_PI_DEF,
  parameter int TRIG_BITS    = ocp_pkg::TRIG_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ocp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ocp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ocp_in_if.sink                         in_i,
  ocp_out_if.source                      out_o
);
  import ocp_pkg::*;

  ocp_cmd_t cmd;

  // Sequencer; it owns the input ready and the output valid.
  ocp_ctrl u_ocp_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // Angles, sine table, multiplier and output payload register.
  ocp_dpath #(
    .STEPS_PER_PI (STEPS_PER_PI),
    .TRIG_BITS    (TRIG_BITS)
  ) u_ocp_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .dx_i        (in_i.dx),
    .dy_i        (in_i.dy),
    .cmd_i       (cmd),
    .pos_x_o     (out_o.pos_x),
    .pos_y_o     (out_o.pos_y),
    .pos_z_o     (out_o.pos_z),
    .heading_o   (out_o.heading),
    .elevation_o (out_o.elevation)
  );

endmodule

### rtl/ocp_checker.sv
// ---------------------------------------------------------------------------
// ocp_checker
// Port-level properties of the orbit camera block, bound to the top level.
// ---------------------------------------------------------------------------
`include "orbit_camera_position_assert.svh"

module ocp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [ocp_pkg::POS_W-1:0]    pos_x_i,
  input logic signed [ocp_pkg::POS_W-1:0]    pos_y_i,
  input logic signed [ocp_pkg::POS_W-1:0]    pos_z_i,
  input logic signed [ocp_pkg::HDG_W-1:0]    heading_i,
  input logic signed [ocp_pkg::ELV_W-1:0]    elevation_i
);
  import ocp_pkg::*;

  logic [3*POS_W+HDG_W+ELV_W-1:0] out_word;

  assign out_word = {pos_x_i, pos_y_i, pos_z_i, heading_i, elevation_i};

  // one move at a time: busy right after a word is taken
  `OCP_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i)
  `OCP_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i)
  `OCP_ASSERT_STABLE(a_out_stable, clk_i, rst_ni, out_valid_i, out_ready_i, out_word)
  // eye is never below the plane while elevation is not negative
  `OCP_ASSERT(a_y_sign, clk_i, rst_ni, (out_valid_i && !elevation_i[ELV_W-1]) |-> !pos_y_i[POS_W-1])

endmodule

bind orbit_camera_position ocp_checker u_ocp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pos_x_i     (out_o.pos_x),
  .pos_y_i     (out_o.pos_y),
  .pos_z_i     (out_o.pos_z),
  .heading_i   (out_o.heading),
  .elevation_i (out_o.elevation)
);

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for orbit_camera_position. Pointer moves go in on the
// input channel. A scoreboard keeps its own heading, elevation and register
// copies and works out each expected eye word. Output words are checked
// field by field in order of arrival. Directed corner moves run first, then
// random moves under several register settings and handshake idle mixes.
// ---------------------------------------------------------------------------
module testbench;
  import ocp_pkg::*;

  // Angle arithmetic at the block's default build
  localparam int STEPS = STEPS_PER_PI_DEF;
  localparam int TURN  = 2 * STEPS;
  localparam int QTR   = STEPS / 2;
  localparam int FRAC  = TRIG_BITS_DEF - 1;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 12;   // covers the block's result latency
  localparam int HOLD_CYCLES = 300;  // long output stall, fills the block
  localparam int CHUNK_ITEMS = 140;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic [HDG_W-1:0] hdg;
    logic [ELV_W-1:0] elv;
  } eye_t;

  // -------------------------------------------------------------------------
  // Eye position scoreboard: angle state, registers, expected words
  // -------------------------------------------------------------------------
  class eye_ledger;
    int          hdg;
    int          elv;
    int          radius;
    int          lim;
    int          errors;
    int unsigned sine_tab[STEPS+1];
    eye_t        eye_q[$];

    function new();
      longint unsigned v;
      int m;
      hdg    = 0;
      elv    = 0;
      radius = DIST_RESET;
      lim    = LIM_RESET;
      errors = 0;
      // half-wave table, mirrored about the quarter turn
      for (int k = 0; k <= STEPS; k++) begin
        m = (2 * k <= STEPS) ? k : STEPS - k;
        v = (taylor_q30(m) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
        if (v > (64'd1 << FRAC)) v = 64'd1 << FRAC;
        sine_tab[k] = int'(v);
      end
    endfunction

    // sin(pi*k/STEPS) in Q2.30, eleven Taylor terms with truncated products
    function longint unsigned taylor_q30(int k);
      longint unsigned x, s, t;
      x = (64'd3373259426 * longint'(k)) / longint'(STEPS);
      s = x;
      t = x;
      for (longint unsigned n = 1; n <= 10; n++) begin
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / ((2 * n) * (2 * n + 1));
        if (n[0]) s = s - t;
        else s = s + t;
      end
      return s;
    endfunction

    function int unsigned sine_mag(int a, output bit neg);
      int r;
      r = a % TURN;
      if (r < 0) r += TURN;
      if (r <= STEPS) begin
        neg = 1'b0;
        return sine_tab[r];
      end
      neg = 1'b1;
      return sine_tab[r - STEPS];
    endfunction

    function longint unsigned qmul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << (FRAC - 1))) >> FRAC;
    endfunction

    function logic [POS_W-1:0] with_sign(longint unsigned mag, bit neg);
      longint unsigned v;
      v = neg ? (64'd0 - mag) : mag;
      return v[POS_W-1:0];
    endfunction

    function int clip_move(int v);
      if (v > TURN) return TURN;
      if (v < -TURN) return -TURN;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DISTANCE) radius = int'(data);
      else if (idx == REG_ELEV_LIMIT) lim = int'(data[LIM_W-1:0]);
    endfunction

    // accepted move: advance the angles and queue the eye word it yields
    function void note_move(logic signed [MOVE_W-1:0] dx, logic signed [MOVE_W-1:0] dy);
      int h, e, cap;
      bit se_n, ce_n, sh_n, ch_n;
      longint unsigned se, ce, sh, ch, t;
      eye_t w;
      h = hdg + clip_move(int'(dx));
      if (h > TURN) h -= TURN;
      else if (h < -TURN) h += TURN;
      hdg = h;
      cap = (lim > QTR) ? QTR : lim;
      e = elv + clip_move(int'(dy));
      if (e > cap) e = cap;
      else if (e < -cap) e = -cap;
      elv = e;
      se = sine_mag(e, se_n);
      ce = sine_mag(e + QTR, ce_n);
      sh = sine_mag(h, sh_n);
      ch = sine_mag(h + QTR, ch_n);
      t = qmul(radius, ce);
      w.x   = with_sign(qmul(t, ch), ce_n != ch_n);
      w.y   = with_sign(qmul(radius, se), se_n);
      w.z   = with_sign(qmul(t, sh), ce_n != sh_n);
      w.hdg = HDG_W'(h);
      w.elv = ELV_W'(e);
      eye_q.push_back(w);
    endfunction

    function void field_cmp(string name, logic signed [POS_W-1:0] want,
                            logic signed [POS_W-1:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_eye(eye_t got);
      eye_t want;
      if (eye_q.size() == 0) begin
        $error("eye word with nothing expected");
        errors++;
        return;
      end
      want = eye_q.pop_front();
      field_cmp("pos_x", $signed(want.x), $signed(got.x));
      field_cmp("pos_y", $signed(want.y), $signed(got.y));
      field_cmp("pos_z", $signed(want.z), $signed(got.z));
      field_cmp("heading", $signed(want.hdg), $signed(got.hdg));
      field_cmp("elevation", $signed(want.elv), $signed(got.elv));
    endfunction

    function int pending();
      return eye_q.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels, block
  // -------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ocp_in_if  in_if ();
  ocp_out_if out_if ();

  orbit_camera_position dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  eye_ledger sb = new();

  int snd_idle_pct = 0;  // chance per cycle that the sender holds back
  int rcv_idle_pct = 0;  // chance per cycle that the receiver drops ready
  bit hold_req     = 1'b0;
  int cycles       = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("orbit_camera_position verification failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: checks each accepted word, then drives ready for the next
  // edge. A hold request turns into a long ready-low stretch counted here.
  // -------------------------------------------------------------------------
  initial begin : eye_sink
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready)
        sb.check_eye({out_if.pos_x, out_if.pos_y, out_if.pos_z,
                      out_if.heading, out_if.elevation});
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender side
  // -------------------------------------------------------------------------

  // Offers one move and returns at the edge that takes it. Valid is left
  // high so back-to-back moves never toggle it within one step.
  task automatic send_move(logic signed [MOVE_W-1:0] dx, logic signed [MOVE_W-1:0] dy);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.dx    <= dx;
    in_if.dy    <= dy;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_move(dx, dy);
  endtask

  // Stop offering, let every expected word drain, then give the block
  // its latency before anything else happens.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Register write; only called after settle()
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
    sb.set_reg(idx, CFG_DATA_W'(data));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random move: mostly legal sizes, some near the saturation edge, some
  // raw 11-bit patterns so every input bit toggles.
  function automatic logic signed [MOVE_W-1:0] pick_move();
    int kind, v;
    kind = $urandom_range(99);
    if (kind < 10) return MOVE_W'($urandom_range(2047));
    if (kind < 25) begin
      v = 799 + int'($urandom_range(2));
      return MOVE_W'($urandom_range(1) ? v : -v);
    end
    if (kind < 55) return MOVE_W'(int'($urandom_range(800)) - 400);
    return MOVE_W'(int'($urandom_range(60)) - 30);
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int mode;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_DISTANCE;
    cfg_data_i  <= '0;
    in_if.valid <= 1'b0;
    in_if.dx    <= '0;
    in_if.dy    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // ---- directed: reset registers (radius 5.0, limit 199) ----
    send_move(11'sd0, 11'sd0);         // eye straight out on x
    send_move(11'sd1023, 11'sd1023);   // both saturate; heading lands on +turn, kept
    send_move(11'sd1, -11'sd1024);     // heading passes +turn and wraps; elevation floor
    send_move(-11'sd1024, 11'sd0);     // saturated negative move
    send_move(-11'sd2, 11'sd0);        // passes -turn, wraps up
    send_move(-11'sd799, 11'sd0);      // exactly -turn is kept
    send_move(-11'sd1, 11'sd0);        // passes -turn again, wraps up
    send_move(11'sd801, 11'sd801);     // just over saturation; elevation ceiling
    send_move(-11'sd801, -11'sd801);
    send_move(11'sd400, 11'sd100);     // quadrant boundaries
    send_move(11'sd200, -11'sd100);
    send_move(-11'sd600, 11'sd50);
    send_move(11'sh555, 11'sh2AA);     // alternating bit patterns
    send_move(11'sh2AA, 11'sh555);
    send_move(11'sd0, 11'sd800);       // park elevation at the limit

    // lowered limit: stored elevation clamps on the next move
    settle();
    cfg_write(REG_ELEV_LIMIT, 50);
    send_move(11'sd0, 11'sd0);
    send_move(11'sd0, -11'sd800);

    // limit beyond a quarter turn acts as a quarter turn
    settle();
    cfg_write(REG_ELEV_LIMIT, 255);
    send_move(11'sd0, 11'sd800);       // straight up
    send_move(11'sd0, -11'sd800);      // straight down

    // radius extremes
    settle();
    cfg_write(REG_DISTANCE, 0);
    send_move(11'sd123, 11'sd233);
    settle();
    cfg_write(REG_DISTANCE, 65535);
    send_move(11'sd0, 11'sd200);       // elevation to the ceiling: straight up
    send_move(-11'sd123, 11'sd0);      // heading to -2; x stays zero straight up
    send_move(11'sd200, 11'sd0);       // heading to 198; z stays zero straight up

    // ---- random chunks: new registers each, idle mix per pair ----
    for (int c = 0; c < 6; c++) begin
      settle();
      case (c)
        0: begin
          cfg_write(REG_DISTANCE, 65535);
          cfg_write(REG_ELEV_LIMIT, 200);
        end
        1: begin
          cfg_write(REG_DISTANCE, 0);
          cfg_write(REG_ELEV_LIMIT, 0);
        end
        2: begin
          cfg_write(REG_DISTANCE, $urandom_range(65535));
          cfg_write(REG_ELEV_LIMIT, 255);
        end
        3: begin
          cfg_write(REG_DISTANCE, $urandom_range(4096));
          cfg_write(REG_ELEV_LIMIT, $urandom_range(255));
        end
        4: begin
          cfg_write(REG_DISTANCE, 1);
          cfg_write(REG_ELEV_LIMIT, 201);
        end
        default: begin
          cfg_write(REG_DISTANCE, $urandom_range(65535));
          cfg_write(REG_ELEV_LIMIT, $urandom_range(200));
        end
      endcase

      mode = c / 2;
      snd_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 57 : 0;
      rcv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 22 : 0;

      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        // long output stall while moves keep coming: block backs up
        if (n == 30 && (c == 0 || c == 5)) hold_req = 1'b1;
        // sender pause until the pipe is empty
        if (n == 90) settle();
        send_move(pick_move(), pick_move());
      end
    end

    settle();
    if (sb.errors == 0)
      $display("orbit_camera_position verification clean");
    else
      $display("orbit_camera_position verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ocp_pkg.sv
rtl/ocp_in_if.sv
rtl/ocp_out_if.sv
rtl/ocp_ctrl.sv
rtl/ocp_dpath.sv
rtl/orbit_camera_position.sv
rtl/ocp_checker.sv
tb/testbench.sv
